// ===== rtl/fbfl_pkg.sv =====
// shared constants, codes and types of the fixed block free list allocator
`timescale 1ns / 1ps

package fbfl_pkg;

  // pool geometry
  localparam int MAX_BLOCKS   = 1024;
  localparam int HEADER_BYTES = 8;
  localparam int ALIGN_BYTES  = 8;

  localparam int IDX_W       = $clog2(MAX_BLOCKS);
  localparam int LINK_W      = IDX_W + 1;
  localparam int BYTES_W     = 13;
  localparam int BYTES_CAP   = 4096;
  localparam int ALIGN_SHIFT = $clog2(ALIGN_BYTES);
  localparam int WORDS_W     = BYTES_W + 1 - ALIGN_SHIFT;
  localparam int OFFSET_W    = 22;

  // end-of-list code in the link memory and the head register
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);

  // register map
  localparam logic REG_BLOCK_COUNT = 1'b0;
  localparam logic REG_BLOCK_BYTES = 1'b1;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_INIT  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  // one access to the link memory
  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [LINK_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
  } mem_req_t;

  // controller status seen by the top level
  typedef struct packed {
    logic [LINK_W-1:0] head;
    logic              pend_valid;
  } ctrl_status_t;

endpackage

// ===== rtl/fbfl_link_ram.sv =====
// next-link memory, one write port and one registered read port
`timescale 1ns / 1ps

module fbfl_link_ram (
  input  logic                      clk,
  input  fbfl_pkg::mem_req_t        mem_req,
  output logic [fbfl_pkg::LINK_W-1:0] rd_data
);
  import fbfl_pkg::*;

  logic [LINK_W-1:0] mem [MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rd_data <= mem[mem_req.rd_addr];
    end
  end

endmodule

// ===== rtl/fbfl_ctrl.sv =====
// request sequencer: head and count registers, init walk, result stage
`timescale 1ns / 1ps

module fbfl_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    action,
  input  logic [fbfl_pkg::IDX_W-1:0]    block_index,
  input  logic [fbfl_pkg::LINK_W-1:0]   block_count,
  input  logic [fbfl_pkg::BYTES_W-1:0]  block_bytes,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic                          granted,
  output logic [fbfl_pkg::IDX_W-1:0]    given_index,
  output logic [fbfl_pkg::OFFSET_W-1:0] given_offset,
  output logic [fbfl_pkg::LINK_W-1:0]   free_count,
  output fbfl_pkg::mem_req_t            mem_req,
  input  logic [fbfl_pkg::LINK_W-1:0]   rd_data,
  output fbfl_pkg::ctrl_status_t        status
);
  import fbfl_pkg::*;

  localparam int PROD_W     = IDX_W + WORDS_W;
  localparam int OFF_FULL_W = PROD_W + ALIGN_SHIFT + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_INIT
  } state_t;

  typedef struct packed {
    logic                granted;
    logic [IDX_W-1:0]    index;
    logic [OFFSET_W-1:0] offset;
    logic [LINK_W-1:0]   count;
  } result_t;

  state_t            state;
  logic [LINK_W-1:0] head_link;
  logic [LINK_W-1:0] free_total;
  logic [LINK_W-1:0] init_n;
  logic [IDX_W-1:0]  init_ptr;
  logic              pend_valid;
  result_t           pend;

  action_t             act;
  logic                accept;
  logic                slot_free;
  logic                head_empty;
  logic [BYTES_W-1:0]  bb_cap;
  logic [BYTES_W:0]    bb_sum;
  logic [WORDS_W-1:0]  words;
  logic [PROD_W-1:0]   prod;
  logic [OFF_FULL_W-1:0] off_full;
  logic [LINK_W-1:0]   init_n_in;
  logic [LINK_W-1:0]   total_dec;
  logic [LINK_W-1:0]   total_inc;
  logic [LINK_W-1:0]   init_nxt;
  logic                init_last;
  logic                fin;
  result_t             fin_res;

  assign act        = action_t'(action);
  assign req_stall  = (state != ST_IDLE) || pend_valid;
  assign accept     = req_valid && !req_stall;
  assign slot_free  = !rsp_valid || !rsp_stall;
  assign head_empty = (head_link >= NULL_LINK);

  // block size capped at 4096 bytes, rounded up to the alignment, counted in alignment units
  assign bb_cap   = (block_bytes > BYTES_W'(BYTES_CAP)) ? BYTES_W'(BYTES_CAP) : block_bytes;
  assign bb_sum   = {1'b0, bb_cap} + (BYTES_W + 1)'(ALIGN_BYTES - 1);
  assign words    = WORDS_W'(bb_sum >> ALIGN_SHIFT);
  assign prod     = PROD_W'(head_link[IDX_W-1:0]) * PROD_W'(words);
  assign off_full = OFF_FULL_W'(HEADER_BYTES) + (OFF_FULL_W'(prod) << ALIGN_SHIFT);

  assign init_n_in = (block_count > NULL_LINK) ? NULL_LINK : block_count;
  assign total_dec = (free_total != '0) ? LINK_W'(free_total - 1'b1) : free_total;
  assign total_inc = (free_total < NULL_LINK) ? LINK_W'(free_total + 1'b1) : free_total;
  assign init_nxt  = LINK_W'(init_ptr) + LINK_W'(1);
  assign init_last = (init_nxt >= init_n);

  // result of the item that finishes in this cycle
  always_comb begin
    fin             = 1'b0;
    fin_res.granted = 1'b0;
    fin_res.index   = '0;
    fin_res.offset  = '0;
    fin_res.count   = free_total;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (act)
            ACT_ALLOC: begin
              fin = 1'b1;
              if (!head_empty) begin
                fin_res.granted = 1'b1;
                fin_res.index   = head_link[IDX_W-1:0];
                fin_res.offset  = OFFSET_W'(off_full);
                fin_res.count   = total_dec;
              end
            end
            ACT_FREE: begin
              fin             = 1'b1;
              fin_res.granted = 1'b1;
              fin_res.count   = total_inc;
            end
            ACT_INIT: begin
              if (init_n_in == '0) begin
                fin             = 1'b1;
                fin_res.granted = 1'b1;
                fin_res.count   = '0;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ST_INIT: begin
        if (init_last) begin
          fin             = 1'b1;
          fin_res.granted = 1'b1;
          fin_res.count   = init_n;
        end
      end
      default: begin
      end
    endcase
  end

  // link memory accesses
  always_comb begin
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = block_index;
    mem_req.wr_data = head_link;
    mem_req.rd_en   = 1'b0;
    mem_req.rd_addr = head_link[IDX_W-1:0];
    case (state)
      ST_IDLE: begin
        if (accept && act == ACT_ALLOC && !head_empty) begin
          mem_req.rd_en = 1'b1;
        end
        if (accept && act == ACT_FREE) begin
          mem_req.wr_en = 1'b1;
        end
      end
      ST_INIT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = init_ptr;
        mem_req.wr_data = init_last ? NULL_LINK : init_nxt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head_link  <= NULL_LINK;
      free_total <= '0;
      rsp_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (act)
              ACT_ALLOC: begin
                if (!head_empty) begin
                  free_total <= total_dec;
                  state      <= ST_POP;
                end
              end
              ACT_FREE: begin
                head_link  <= {1'b0, block_index};
                free_total <= total_inc;
              end
              ACT_INIT: begin
                if (init_n_in == '0) begin
                  head_link  <= NULL_LINK;
                  free_total <= '0;
                end else begin
                  init_n   <= init_n_in;
                  init_ptr <= '0;
                  state    <= ST_INIT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_POP: begin
          head_link <= (rd_data > NULL_LINK) ? NULL_LINK : rd_data;
          state     <= ST_IDLE;
        end
        ST_INIT: begin
          init_ptr <= init_nxt[IDX_W-1:0];
          if (init_last) begin
            head_link  <= '0;
            free_total <= init_n;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // output word, with one held-back result while the output is stalled
      if (slot_free) begin
        if (pend_valid) begin
          {granted, given_index, given_offset, free_count} <= pend;
          rsp_valid  <= 1'b1;
          pend_valid <= 1'b0;
        end else if (fin) begin
          {granted, given_index, given_offset, free_count} <= fin_res;
          rsp_valid <= 1'b1;
        end else begin
          rsp_valid <= 1'b0;
        end
      end else if (fin) begin
        pend       <= fin_res;
        pend_valid <= 1'b1;
      end
    end
  end

  assign status.head       = head_link;
  assign status.pend_valid = pend_valid;

endmodule

// ===== rtl/fixed_block_free_list_allocator.sv =====
// top level of the fixed block free list allocator: config registers and wiring
`timescale 1ns / 1ps

//  channel  | direction | handshake            | word
//  ---------+-----------+----------------------+-----------------------------------------
//  req      | in        | req_valid/req_stall  | action, block_index
//  rsp      | out       | rsp_valid/rsp_stall  | granted, given_index, given_offset, free_count
//  config   | in        | apb psel/penable     | block_count @ 0x0, block_bytes @ 0x4
//
//  free, no-op and alloc on an empty list finish as they are taken; a granted alloc
//  then passes the pop state for the registered read of the head link in the link memory.
//  init walks min(block_count, 1024) blocks before it finishes: the write port sweeps one
//  block per cycle. the link memory has no clearing pass and is unreset. one
//  finished word waits in the output register and one more is held back while rsp_stall
//  is high; a new request is taken once that hold slot is empty and the sequencer is idle.

module fixed_block_free_list_allocator (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    action,
  input  logic [fbfl_pkg::IDX_W-1:0]    block_index,
  // result channel
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic                          granted,
  output logic [fbfl_pkg::IDX_W-1:0]    given_index,
  output logic [fbfl_pkg::OFFSET_W-1:0] given_offset,
  output logic [fbfl_pkg::LINK_W-1:0]   free_count,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import fbfl_pkg::*;

  logic [LINK_W-1:0]  block_count;
  logic [BYTES_W-1:0] block_bytes;
  logic               cfg_wr;
  logic               reg_sel;
  mem_req_t           mem_req;
  logic [LINK_W-1:0]  rd_data;
  ctrl_status_t       status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  // word address, byte lane bits ignored
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= LINK_W'(1024);
      block_bytes <= BYTES_W'(8);
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_BLOCK_COUNT: block_count <= pwdata[LINK_W-1:0];
        REG_BLOCK_BYTES: block_bytes <= pwdata[BYTES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BLOCK_COUNT: prdata = 32'(block_count);
      REG_BLOCK_BYTES: prdata = 32'(block_bytes);
      default:         prdata = '0;
    endcase
  end

  // sequencer: pops, pushes, init walk and the result stage
  fbfl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .action       (action),
    .block_index  (block_index),
    .block_count  (block_count),
    .block_bytes  (block_bytes),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .granted      (granted),
    .given_index  (given_index),
    .given_offset (given_offset),
    .free_count   (free_count),
    .mem_req      (mem_req),
    .rd_data      (rd_data),
    .status       (status)
  );

  // one next link per block
  fbfl_link_ram u_link_ram (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

`ifndef ASSERT_OFF
  // a pop and a push or init write never share a cycle
  a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem_req.rd_en && mem_req.wr_en))
    else $error("link memory read and write in the same cycle");

  // the head register holds a block index or the end-of-list code
  a_head_in_range: assert property (@(posedge clk) disable iff (rst)
    status.head <= NULL_LINK)
    else $error("head link out of range");

  // no new request while a result is held back
  a_hold_blocks_req: assert property (@(posedge clk) disable iff (rst)
    status.pend_valid |-> req_stall)
    else $error("request taken while a result is held back");

  // a result is only held back behind a stalled output word
  a_hold_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(status.pend_valid) |-> $past(rsp_valid && rsp_stall))
    else $error("result held back without a stalled output");
`endif

endmodule

// ===== sim/fixed_block_free_list_allocator_tb.sv =====
// testbench of the fixed block free list allocator: random and directed requests, scoreboard
`timescale 1ns / 1ps

module fixed_block_free_list_allocator_tb;
  import fbfl_pkg::*;

  // run limits
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 100;
  localparam int SETTLE_WAIT  = 50;

  // one result word as the block reports it
  typedef struct packed {
    logic                granted;
    logic [IDX_W-1:0]    index;
    logic [OFFSET_W-1:0] offset;
    logic [LINK_W-1:0]   count;
  } grant_word_t;

  // free list predictor plus the queue of result words still awaited
  class alloc_scoreboard;
    logic [LINK_W-1:0] links [MAX_BLOCKS];
    logic [LINK_W-1:0] head;
    int unsigned       free_total;
    int unsigned       count_reg;
    int unsigned       bytes_reg;
    grant_word_t       awaited [$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      head       = NULL_LINK;
      free_total = 0;
      count_reg  = 1024;
      bytes_reg  = 8;
      errors     = 0;
      checked    = 0;
      foreach (links[i]) links[i] = '0;
    endfunction

    function void write_reg(logic reg_sel, logic [31:0] value);
      if (reg_sel == REG_BLOCK_COUNT) count_reg = value & 32'h7FF;
      else bytes_reg = value & 32'h1FFF;
    endfunction

    // apply one accepted request to the predicted list, queue its result word
    function grant_word_t note_request(action_t act, logic [IDX_W-1:0] idx);
      grant_word_t      w;
      int unsigned      n;
      int unsigned      stride;
      logic [IDX_W-1:0] blk;
      longint unsigned  off;
      w = '0;
      case (act)
        ACT_ALLOC: begin
          if (head < NULL_LINK) begin
            blk    = head[IDX_W-1:0];
            stride = (bytes_reg > BYTES_CAP) ? BYTES_CAP : bytes_reg;
            stride = (stride + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
            off    = HEADER_BYTES + longint'(blk) * stride;
            w.granted = 1'b1;
            w.index   = blk;
            w.offset  = OFFSET_W'(off);
            head = links[blk];
            if (head > NULL_LINK) head = NULL_LINK;
            if (free_total > 0) free_total--;
          end
        end
        ACT_FREE: begin
          // a 10-bit index is always below the null code, so free always succeeds
          links[idx] = head;
          head = {1'b0, idx};
          if (free_total < MAX_BLOCKS) free_total++;
          w.granted = 1'b1;
        end
        ACT_INIT: begin
          n = (count_reg > MAX_BLOCKS) ? MAX_BLOCKS : count_reg;
          for (int unsigned i = 0; i < n; i++)
            links[i] = (i + 1 < n) ? LINK_W'(i + 1) : NULL_LINK;
          head = (n > 0) ? '0 : NULL_LINK;
          free_total = n;
          w.granted = 1'b1;
        end
        default: ;
      endcase
      w.count = LINK_W'(free_total);
      awaited.push_back(w);
      return w;
    endfunction

    function void check_result(grant_word_t got);
      grant_word_t want;
      if (awaited.size() == 0) begin
        $error("result word with nothing awaited: granted %0d index %0d offset %0d count %0d",
               got.granted, got.index, got.offset, got.count);
        errors++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got.granted !== want.granted) begin
        $error("granted: expected %0d, got %0d", want.granted, got.granted);
        errors++;
      end
      if (got.index !== want.index) begin
        $error("given_index: expected %0d, got %0d", want.index, got.index);
        errors++;
      end
      if (got.offset !== want.offset) begin
        $error("given_offset: expected %0d, got %0d", want.offset, got.offset);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("free_count: expected %0d, got %0d", want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  // clock, reset and every block input start at known values
  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                req_valid   = 1'b0;
  logic [1:0]          action      = ACT_NOP;
  logic [IDX_W-1:0]    block_index = '0;
  logic                rsp_stall   = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [2:0]          paddr       = '0;
  logic [31:0]         pwdata      = '0;

  logic                req_stall;
  logic                rsp_valid;
  logic                granted;
  logic [IDX_W-1:0]    given_index;
  logic [OFFSET_W-1:0] given_offset;
  logic [LINK_W-1:0]   free_count;
  logic [31:0]         prdata;
  logic                pready;

  alloc_scoreboard  board;
  logic [IDX_W-1:0] held [$];     // blocks handed out and not yet given back
  int unsigned      sent_words   = 0;
  int unsigned      cycle_count  = 0;
  int unsigned      send_idle_pct  = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      hold_asks    = 0;   // bumped by the main flow to ask for a long hold-off
  int unsigned      hold_seen    = 0;
  int unsigned      hold_left    = 0;

  fixed_block_free_list_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .action       (action),
    .block_index  (block_index),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .granted      (granted),
    .given_index  (given_index),
    .given_offset (given_offset),
    .free_count   (free_count),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // global watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: check every accepted word, then pick the next stall value
  // a long hold-off, once asked, is counted down here
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall)
        board.check_result({granted, given_index, given_offset, free_count});
      if (hold_asks != hold_seen) begin
        hold_seen <= hold_asks;
        hold_left <= HOLD_CYCLES;
        rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // offer one request word, wait for it to be taken, predict its result
  // valid stays high afterwards so back-to-back words need no gap
  task automatic send_word(input action_t act, input logic [IDX_W-1:0] idx);
    grant_word_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid   <= 1'b1;
    action      <= act;
    block_index <= idx;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    w = board.note_request(act, idx);
    sent_words++;
    if (act == ACT_INIT) held.delete();
    else if (act == ACT_ALLOC && w.granted) held.push_back(w.index);
  endtask

  // stop offering and wait until every awaited word has come back
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write: setup cycle then access cycle; only called while drained
  task automatic write_reg(input logic reg_sel, input logic [31:0] value);
    logic [31:0] want;
    want = (reg_sel == REG_BLOCK_COUNT) ? (value & 32'h7FF) : (value & 32'h1FFF);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.write_reg(reg_sel, value);
    @(posedge clk);
    // read back the register just written
    if (prdata !== want) begin
      $error("prdata: expected %0d, got %0d", want, prdata);
      board.errors++;
    end
  endtask

  task automatic set_pool(input int unsigned blocks, input int unsigned bytes);
    write_reg(REG_BLOCK_COUNT, blocks);
    write_reg(REG_BLOCK_BYTES, bytes);
  endtask

  // mostly alloc and give-back of held blocks; some stray frees, inits and no-ops
  task automatic send_random_word();
    int unsigned      r;
    int unsigned      k;
    action_t          act;
    logic [IDX_W-1:0] idx;
    r   = $urandom_range(99);
    idx = IDX_W'($urandom);
    if (r < 45) begin
      act = ACT_ALLOC;
    end else if (r < 82) begin
      act = ACT_FREE;
      if (held.size() != 0 && r < 77) begin
        k   = $urandom_range(held.size() - 1);
        idx = held[k];
        held.delete(k);
      end
    end else if (r < 86) begin
      act = ACT_INIT;
    end else if (r < 92) begin
      act = ACT_NOP;
    end else begin
      act = ACT_ALLOC;
    end
    send_word(act, idx);
  endtask

  initial begin
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list, no-op, lifo order, full pool from reset config
    send_word(ACT_ALLOC, '0);            // empty list after reset
    send_word(ACT_NOP, '1);
    send_word(ACT_FREE, '0);
    send_word(ACT_FREE, '1);
    send_word(ACT_ALLOC, '0);            // last freed comes out first
    send_word(ACT_ALLOC, '1);
    send_word(ACT_ALLOC, '0);            // empty again
    send_word(ACT_INIT, '0);             // 1024 blocks of 8 bytes
    send_word(ACT_ALLOC, '0);
    send_word(ACT_ALLOC, '0);
    send_word(ACT_FREE, '1);             // count one below the full pool
    send_word(ACT_FREE, '1);             // double free, count back at the full pool
    send_word(ACT_ALLOC, '0);
    send_word(ACT_ALLOC, '0);            // self-linked block comes out again
    wait_drained();

    // zero block count: init leaves an empty list
    set_pool(0, 24);
    send_word(ACT_INIT, '1);
    send_word(ACT_ALLOC, '0);
    send_word(ACT_FREE, 10'd5);
    send_word(ACT_ALLOC, '0);
    wait_drained();

    // oversized count and size saturate
    set_pool(2047, 8191);
    send_word(ACT_INIT, '0);
    send_word(ACT_ALLOC, '0);
    send_word(ACT_ALLOC, '0);
    send_word(ACT_NOP, '0);
    wait_drained();

    // zero size: every offset is just the header
    set_pool(2047, 0);
    send_word(ACT_ALLOC, '0);
    send_word(ACT_FREE, '1);
    send_word(ACT_ALLOC, '0);
    wait_drained();

    // random phases, each with its own pool setting and idling mode
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      case (p)
        0: set_pool($urandom_range(32, 2), $urandom_range(64, 1));
        1: set_pool(2047, 8191);
        2: set_pool(1, 0);
        3: set_pool(0, $urandom_range(8191));
        4: set_pool($urandom_range(16, 1), 4096);
        5: set_pool(1024, 4097);
        6: set_pool($urandom_range(2047), $urandom_range(8191));
        default: set_pool($urandom_range(64, 3), 1);
      endcase
      send_word(ACT_INIT, IDX_W'($urandom));
      for (int i = 1; i < PHASE_WORDS; i++) begin
        // long receiver hold-off while requests keep coming, so the block backs up
        if ((p == 0 || p == 5) && i == PHASE_WORDS / 2) hold_asks <= hold_asks + 1;
        send_random_word();
      end
    end

    wait_drained();
    repeat (SETTLE_WAIT) @(posedge clk);
    $display("covered %0d request words over %0d pool settings and four idling modes",
             sent_words, PHASES + 4);
    $display("%0d result words checked, %0d mismatches", board.checked, board.errors);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
